// ----- hdl/szp_pkg.sv -----
// ----------------------------------------------------------------------------
// szp_pkg: shared types and constants for the subpixel pattern unit
// Channel level tables, size limits and the record handed from the front
// end to the back end through the item queue.
// ----------------------------------------------------------------------------
`default_nettype none

package szp_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int CHAN_W  = 8;
	localparam int SIZE_W  = 11;
	localparam int CNT_W   = 10;
	localparam int COORD_W = 12;
	localparam int ADDR_W  = 24;
	localparam int IDX_W   = 2;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [CHAN_W-1:0] LEVEL_ONE_MAX   = 8'd74;
	localparam logic [CHAN_W-1:0] LEVEL_TWO_MAX   = 8'd134;
	localparam logic [CHAN_W-1:0] LEVEL_THREE_MAX = 8'd179;
	localparam logic [CHAN_W-1:0] FULL_ON         = 8'd255;

	localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;

	// Block row and column position codes inside one 3x3 block.
	localparam logic [1:0] POS_FIRST = 2'd0;
	localparam logic [1:0] POS_MID   = 2'd1;
	localparam logic [1:0] POS_LAST  = 2'd2;

	typedef logic [2:0] rows_t;

	typedef struct packed {
		rows_t                red_rows;
		rows_t                green_rows;
		rows_t                blue_rows;
		logic [COORD_W-1:0]   row_base;
		logic [COORD_W-1:0]   col_base;
		logic [ADDR_W-1:0]    addr_base;
		logic [COORD_W-1:0]   line_pitch;
		logic                 image_end;
	} item_t;

	// Bit r set means block row r is lit for this channel value.
	function automatic rows_t lit_rows(input logic [CHAN_W-1:0] v);
		rows_t r;
		if (v <= LEVEL_ONE_MAX) begin
			r = 3'b000;
		end else if (v <= LEVEL_TWO_MAX) begin
			r = 3'b010;
		end else if (v <= LEVEL_THREE_MAX) begin
			r = 3'b101;
		end else begin
			r = 3'b111;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/szp_front.sv -----
// ----------------------------------------------------------------------------
// szp_front: pixel intake and classification
// Holds the size registers and the raster counters, sorts each channel into
// its lit rows and works out the base coordinates and address of the block.
// ----------------------------------------------------------------------------
`default_nettype none

module szp_front import szp_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire logic                q_full,
	input  wire logic [CHAN_W-1:0]   red_in,
	input  wire logic [CHAN_W-1:0]   green_in,
	input  wire logic [CHAN_W-1:0]   blue_in,
	input  wire logic                cfg_valid,
	input  wire logic [IDX_W-1:0]    cfg_index,
	input  wire logic [SIZE_W-1:0]   cfg_data,
	output      logic                q_push,
	output      item_t               q_item
);

	logic [SIZE_W-1:0]  width_q;
	logic [SIZE_W-1:0]  height_q;
	logic [CNT_W-1:0]   col_q;
	logic [CNT_W-1:0]   row_q;

	logic [SIZE_W-1:0]  w_eff;
	logic [SIZE_W-1:0]  h_eff;
	logic [COORD_W-1:0] pitch;
	logic [COORD_W-1:0] row_base;
	logic [COORD_W-1:0] col_base;
	logic               line_end;
	logic               last_row;

	always_comb begin
		if (width_q == '0) begin
			w_eff = SIZE_W'(1);
		end else if (width_q > SIZE_W'(MAX_WIDTH)) begin
			w_eff = SIZE_W'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		if (height_q == '0) begin
			h_eff = SIZE_W'(1);
		end else if (height_q > SIZE_W'(MAX_HEIGHT)) begin
			h_eff = SIZE_W'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
	end

	// Times three as a shift and an add.
	assign pitch    = COORD_W'(w_eff) + COORD_W'({w_eff, 1'b0});
	assign row_base = COORD_W'(row_q) + COORD_W'({row_q, 1'b0});
	assign col_base = COORD_W'(col_q) + COORD_W'({col_q, 1'b0});

	// A counter at or past the last position counts as being on it.
	assign line_end = (SIZE_W'(col_q) + SIZE_W'(1)) >= w_eff;
	assign last_row = (SIZE_W'(row_q) + SIZE_W'(1)) >= h_eff;

	assign q_push = push && !q_full;

	always_comb begin
		q_item.red_rows   = lit_rows(red_in);
		q_item.green_rows = lit_rows(green_in);
		q_item.blue_rows  = lit_rows(blue_in);
		q_item.row_base   = row_base;
		q_item.col_base   = col_base;
		q_item.addr_base  = ADDR_W'(ADDR_W'(row_base) * ADDR_W'(pitch))
			+ ADDR_W'(col_base);
		q_item.line_pitch = pitch;
		q_item.image_end  = line_end && last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_W'(MAX_WIDTH);
			height_q <= SIZE_W'(MAX_HEIGHT);
			col_q    <= '0;
			row_q    <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_WIDTH:  width_q  <= cfg_data;
					REG_HEIGHT: height_q <= cfg_data;
					default:    ;
				endcase
			end
			if (q_push) begin
				if (line_end) begin
					col_q <= '0;
					row_q <= last_row ? '0 : CNT_W'(SIZE_W'(row_q) + SIZE_W'(1));
				end else begin
					col_q <= CNT_W'(SIZE_W'(col_q) + SIZE_W'(1));
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/szp_queue.sv -----
// ----------------------------------------------------------------------------
// szp_queue: short item queue between front and back end
// A small register FIFO of classified pixel records; the head is visible
// without a pop so the back end can step through its nine subpixels.
// ----------------------------------------------------------------------------
`default_nettype none

module szp_queue import szp_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  wr_en,
	input  wire item_t wr_item,
	output      logic  q_full,
	input  wire logic  rd_en,
	output      logic  q_empty,
	output      item_t rd_item
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

	item_t              mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wptr_q;
	logic [PTR_W-1:0]   rptr_q;
	logic [CNT_QW-1:0]  count_q;

	assign q_full  = count_q == CNT_QW'(QUEUE_DEPTH);
	assign q_empty = count_q == '0;
	assign rd_item = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= (wptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
			end
			if (rd_en) begin
				rptr_q <= (rptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
			end
			unique case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + CNT_QW'(1);
				2'b01:   count_q <= count_q - CNT_QW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hdl/szp_back.sv -----
// ----------------------------------------------------------------------------
// szp_back: subpixel sequencer and result register
// Walks the 3x3 block of the queue head, row by row, and places one subpixel
// per cycle into the result register while it is empty or being popped.
// ----------------------------------------------------------------------------
`default_nettype none

module szp_back import szp_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 q_empty,
	input  wire item_t                head,
	output      logic                 q_pop,
	input  wire logic                 pop,
	output      logic                 empty,
	output      logic [CHAN_W-1:0]    red_out,
	output      logic [CHAN_W-1:0]    green_out,
	output      logic [CHAN_W-1:0]    blue_out,
	output      logic [COORD_W-1:0]   out_row,
	output      logic [COORD_W-1:0]   out_col,
	output      logic [ADDR_W-1:0]    out_address,
	output      logic                 last_of_block,
	output      logic                 end_of_image
);

	logic [1:0]         x_q;
	logic [1:0]         y_q;
	logic               out_valid_q;
	logic [CHAN_W-1:0]  red_q;
	logic [CHAN_W-1:0]  green_q;
	logic [CHAN_W-1:0]  blue_q;
	logic [COORD_W-1:0] row_q;
	logic [COORD_W-1:0] col_q;
	logic [ADDR_W-1:0]  addr_q;
	logic               last_q;
	logic               eoi_q;

	logic               advance;
	logic               last_sub;
	logic [ADDR_W-1:0]  row_off;

	assign advance  = !q_empty && (!out_valid_q || pop);
	assign last_sub = (x_q == POS_LAST) && (y_q == POS_LAST);
	assign q_pop    = advance && last_sub;

	always_comb begin
		unique case (x_q)
			POS_FIRST: row_off = '0;
			POS_MID:   row_off = ADDR_W'(head.line_pitch);
			default:   row_off = ADDR_W'({head.line_pitch, 1'b0});
		endcase
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			red_q   <= ((y_q == POS_FIRST) && head.red_rows[x_q])   ? FULL_ON : '0;
			green_q <= ((y_q == POS_MID)   && head.green_rows[x_q]) ? FULL_ON : '0;
			blue_q  <= ((y_q == POS_LAST)  && head.blue_rows[x_q])  ? FULL_ON : '0;
			row_q   <= head.row_base + COORD_W'(x_q);
			col_q   <= head.col_base + COORD_W'(y_q);
			addr_q  <= head.addr_base + row_off + ADDR_W'(y_q);
			last_q  <= last_sub;
			eoi_q   <= last_sub && head.image_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q         <= POS_FIRST;
			y_q         <= POS_FIRST;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				if (y_q == POS_LAST) begin
					y_q <= POS_FIRST;
					x_q <= (x_q == POS_LAST) ? POS_FIRST : x_q + 2'd1;
				end else begin
					y_q <= y_q + 2'd1;
				end
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty         = !out_valid_q;
	assign red_out       = red_q;
	assign green_out     = green_q;
	assign blue_out      = blue_q;
	assign out_row       = row_q;
	assign out_col       = col_q;
	assign out_address   = addr_q;
	assign last_of_block = last_q;
	assign end_of_image  = eoi_q;

	// The queue entry leaves only with the ninth subpixel of its block.
	a_pop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (x_q == POS_LAST && y_q == POS_LAST))
		else $error("queue entry released before its last subpixel");

	a_eoi_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && eoi_q) |-> last_q)
		else $error("end of image flagged off a block end");

	// Inside a block the next subpixel follows the taken one at once.
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !last_q && pop) |=> out_valid_q)
		else $error("gap inside a block");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(x_q != 2'd3) && (y_q != 2'd3))
		else $error("block position out of range");

endmodule

`default_nettype wire

// ----- hdl/subpixel_zoom3x_pattern_unit.sv -----
// ----------------------------------------------------------------------------
// subpixel_zoom3x_pattern_unit: 3x subpixel pattern expander
//
//   channel  signals                          beat
//   input    push / full                      one RGB pixel
//   result   empty / pop                      one subpixel with coordinates
//   config   cfg_valid / cfg_ready            register index and value
//
// Each pixel beat yields nine result beats, one per cycle while pop is held,
// so the sustained pixel rate is set by the sequencer that walks the block.
// Pixels are classified on entry into a two-entry queue, so up to two pixels
// are taken while results are stalled.
// Reset leaves the size registers at 1024 by 1024 and the counters at zero.
// ----------------------------------------------------------------------------
`default_nettype none

module subpixel_zoom3x_pattern_unit import szp_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	output      logic                 full,
	input  wire logic [CHAN_W-1:0]    red_in,
	input  wire logic [CHAN_W-1:0]    green_in,
	input  wire logic [CHAN_W-1:0]    blue_in,
	output      logic                 empty,
	input  wire logic                 pop,
	output      logic [CHAN_W-1:0]    red_out,
	output      logic [CHAN_W-1:0]    green_out,
	output      logic [CHAN_W-1:0]    blue_out,
	output      logic [COORD_W-1:0]   out_row,
	output      logic [COORD_W-1:0]   out_col,
	output      logic [ADDR_W-1:0]    out_address,
	output      logic                 last_of_block,
	output      logic                 end_of_image,
	input  wire logic                 cfg_valid,
	output      logic                 cfg_ready,
	input  wire logic [IDX_W-1:0]     cfg_index,
	input  wire logic [SIZE_W-1:0]    cfg_data
);

	logic  q_push;
	logic  q_pop;
	logic  q_full;
	logic  q_empty;
	item_t wr_item;
	item_t head;

	assign cfg_ready = 1'b1;
	assign full      = q_full;

	szp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.q_full    (q_full),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_push    (q_push),
		.q_item    (wr_item)
	);

	szp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_item (wr_item),
		.q_full  (q_full),
		.rd_en   (q_pop),
		.q_empty (q_empty),
		.rd_item (head)
	);

	szp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.head          (head),
		.q_pop         (q_pop),
		.pop           (pop),
		.empty         (empty),
		.red_out       (red_out),
		.green_out     (green_out),
		.blue_out      (blue_out),
		.out_row       (out_row),
		.out_col       (out_col),
		.out_address   (out_address),
		.last_of_block (last_of_block),
		.end_of_image  (end_of_image)
	);

endmodule

`default_nettype wire
